FILE: src/fbcp_pkg.sv
// Package for the framed box coordinate parser.
// Holds register indexes, reset values, sizing constants and the control struct.
// No dependencies.
`default_nettype none

package fbcp_pkg;

	localparam int unsigned BYTE_W = 8;
	localparam int unsigned CFG_IDX_W = 2;

	// Register indexes of the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_HEADER_FIRST = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HEADER_SECOND = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_END_MARK = 2'd2;

	localparam logic [BYTE_W-1:0] HEADER_FIRST_RST = 8'h2C;
	localparam logic [BYTE_W-1:0] HEADER_SECOND_RST = 8'h12;
	localparam logic [BYTE_W-1:0] END_MARK_RST = 8'h5B;

	localparam int unsigned FRAME_MAX_DEF = 10;
	// Two header bytes, four payload bytes and the end mark.
	localparam int unsigned MIN_FRAME = 7;
	// The cell chain keeps the four newest stored bytes; the four before a frame's last byte are latched.
	localparam int unsigned HIST_CELLS = 4;

	typedef struct packed {
		logic shift;
		logic latch;
		logic emit;
	} fbcp_ctl_t;

endpackage

`default_nettype wire

FILE: src/fbcp_in_if.sv
// Input channel of the framed box coordinate parser: one received byte per beat.
// Depends on fbcp_pkg for the byte width.
`default_nettype none

interface fbcp_in_if;
	logic valid;
	logic ready;
	logic [fbcp_pkg::BYTE_W-1:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

FILE: src/fbcp_out_if.sv
// Output channel of the framed box coordinate parser: one box per beat.
// Depends on fbcp_pkg for the byte width.
`default_nettype none

interface fbcp_out_if;
	logic valid;
	logic ready;
	logic [fbcp_pkg::BYTE_W-1:0] box_x;
	logic [fbcp_pkg::BYTE_W-1:0] box_y;
	logic [fbcp_pkg::BYTE_W-1:0] box_width;
	logic [fbcp_pkg::BYTE_W-1:0] box_height;

	modport source (output valid, output box_x, output box_y, output box_width,
		output box_height, input ready);
	modport sink (input valid, input box_x, input box_y, input box_width,
		input box_height, output ready);
endinterface

`default_nettype wire

FILE: src/fbcp_cell.sv
// One byte cell of the history chain; takes its neighbor's byte on a shift.
// Depends on fbcp_pkg.
`default_nettype none

module fbcp_cell (
	input  wire logic                        clk,
	input  wire logic                        shift,
	input  wire logic [fbcp_pkg::BYTE_W-1:0] d,
	output logic      [fbcp_pkg::BYTE_W-1:0] q
);
	import fbcp_pkg::*;

	logic [BYTE_W-1:0] byte_q;

	always_ff @(posedge clk) begin
		if (shift) begin
			byte_q <= d;
		end
	end

	assign q = byte_q;

endmodule

`default_nettype wire

FILE: src/fbcp_ctrl.sv
// Frame sequencer: header matching, byte count and frame end detection.
// Depends on fbcp_pkg; drives the cell chain and the latch and emit strobes.
`default_nettype none

module fbcp_ctrl #(
	parameter int unsigned FRAME_MAX = fbcp_pkg::FRAME_MAX_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        accept,
	input  wire logic [fbcp_pkg::BYTE_W-1:0] rx_byte,
	input  wire logic [fbcp_pkg::BYTE_W-1:0] header_first,
	input  wire logic [fbcp_pkg::BYTE_W-1:0] header_second,
	input  wire logic [fbcp_pkg::BYTE_W-1:0] end_mark,
	input  wire logic [fbcp_pkg::BYTE_W-1:0] last_byte,
	output logic                             emit_due,
	output fbcp_pkg::fbcp_ctl_t              ctl
);
	import fbcp_pkg::*;

	localparam int unsigned CNT_W = $clog2(FRAME_MAX + 1);

	typedef enum logic [1:0] {
		ST_HDR1,
		ST_HDR2,
		ST_STORE,
		ST_DONE
	} state_t;

	state_t state_q, state_d;
	logic [CNT_W-1:0] cnt_q, cnt_d, cnt_inc;

	assign cnt_inc = cnt_q + CNT_W'(1);

	// The next accepted byte releases a box; known from registers alone.
	assign emit_due = (state_q == ST_DONE) && (last_byte == end_mark);

	always_comb begin
		state_d = state_q;
		cnt_d = cnt_q;
		ctl = '0;
		unique case (state_q)
			ST_HDR1: begin
				if (rx_byte == header_first) begin
					ctl.shift = 1'b1;
					cnt_d = cnt_inc;
					state_d = ST_HDR2;
				end else begin
					cnt_d = '0;
				end
			end
			ST_HDR2: begin
				if (rx_byte == header_second) begin
					ctl.shift = 1'b1;
					cnt_d = cnt_inc;
					state_d = ST_STORE;
				end else begin
					cnt_d = '0;
					state_d = ST_HDR1;
				end
			end
			ST_STORE: begin
				ctl.shift = 1'b1;
				cnt_d = cnt_inc;
				if (cnt_inc == CNT_W'(FRAME_MAX) || rx_byte == end_mark) begin
					// A frame ending before four payload bytes is dropped.
					if (cnt_inc < CNT_W'(MIN_FRAME)) begin
						cnt_d = '0;
						state_d = ST_HDR1;
					end else begin
						ctl.latch = 1'b1;
						state_d = ST_DONE;
					end
				end
			end
			ST_DONE: begin
				// This byte is discarded; the frame counts only if it closed on the end mark.
				ctl.emit = emit_due;
				cnt_d = '0;
				state_d = ST_HDR1;
			end
			default: begin
				cnt_d = '0;
				state_d = ST_HDR1;
			end
		endcase
		if (!accept) begin
			ctl = '0;
			state_d = state_q;
			cnt_d = cnt_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_HDR1;
			cnt_q <= '0;
		end else begin
			state_q <= state_d;
			cnt_q <= cnt_d;
		end
	end

endmodule

`default_nettype wire

FILE: src/framed_box_coordinate_parser_core.sv
// Framed box coordinate parser: one received byte is taken on every cycle unless input is held off.
// The box appears in the cycle after the byte that follows the frame's last byte is taken.
// The sequencer and the byte cell chain take one byte per cycle while input is not held off.
// A result waiting at the output does not stop input unless it is stalled while a new one is due.
// Reset (arst_n low) returns the sequencer to header search, the config registers to defaults and clears box valid.
`default_nettype none

module framed_box_coordinate_parser_core #(
	parameter int unsigned FRAME_MAX = fbcp_pkg::FRAME_MAX_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [fbcp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [fbcp_pkg::BYTE_W-1:0]    cfg_wdata,
	fbcp_in_if.sink                             rx,
	fbcp_out_if.source                          box
);
	import fbcp_pkg::*;

	logic [BYTE_W-1:0] header_first_q, header_second_q, end_mark_q;
	logic [BYTE_W-1:0] cell_q [HIST_CELLS];
	logic [BYTE_W-1:0] lat_x_q, lat_y_q, lat_w_q, lat_h_q;
	logic [BYTE_W-1:0] box_x_q, box_y_q, box_w_q, box_h_q;
	logic box_vld_q;
	logic accept;
	logic emit_due;
	fbcp_ctl_t ctl;

	// Input is held off only when the next byte would release a box that has nowhere to go.
	assign rx.ready = !box_vld_q || box.ready || !emit_due;
	assign accept = rx.valid && rx.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_first_q <= HEADER_FIRST_RST;
			header_second_q <= HEADER_SECOND_RST;
			end_mark_q <= END_MARK_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_HEADER_FIRST:  header_first_q <= cfg_wdata;
				REG_HEADER_SECOND: header_second_q <= cfg_wdata;
				REG_END_MARK:      end_mark_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	fbcp_ctrl #(.FRAME_MAX(FRAME_MAX)) u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (accept),
		.rx_byte       (rx.rx_byte),
		.header_first  (header_first_q),
		.header_second (header_second_q),
		.end_mark      (end_mark_q),
		.last_byte     (cell_q[0]),
		.emit_due      (emit_due),
		.ctl           (ctl)
	);

	// Cell zero holds the newest stored byte, the highest cell the oldest.
	for (genvar i = 0; i < HIST_CELLS; i++) begin : g_cell
		if (i == 0) begin : g_head
			fbcp_cell u_cell (
				.clk   (clk),
				.shift (ctl.shift),
				.d     (rx.rx_byte),
				.q     (cell_q[i])
			);
		end else begin : g_body
			fbcp_cell u_cell (
				.clk   (clk),
				.shift (ctl.shift),
				.d     (cell_q[i-1]),
				.q     (cell_q[i])
			);
		end
	end

	// Latch on the end byte itself, so the chain is read before it shifts.
	always_ff @(posedge clk) begin
		if (ctl.latch) begin
			lat_x_q <= cell_q[3];
			lat_y_q <= cell_q[2];
			lat_w_q <= cell_q[1];
			lat_h_q <= cell_q[0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_vld_q <= 1'b0;
		end else if (ctl.emit) begin
			box_vld_q <= 1'b1;
		end else if (box.ready) begin
			box_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.emit) begin
			box_x_q <= lat_x_q;
			box_y_q <= lat_y_q;
			box_w_q <= lat_w_q;
			box_h_q <= lat_h_q;
		end
	end

	assign box.valid = box_vld_q;
	assign box.box_x = box_x_q;
	assign box.box_y = box_y_q;
	assign box.box_width = box_w_q;
	assign box.box_height = box_h_q;

endmodule

`default_nettype wire

FILE: src/fbcp_checker.sv
// Port-level checks for the framed box coordinate parser, bound to the top level.
// Depends on fbcp_pkg for the byte width.
`default_nettype none

module fbcp_checker (
	input wire logic                        clk,
	input wire logic                        arst_n,
	input wire logic                        rx_valid,
	input wire logic                        rx_ready,
	input wire logic                        box_valid,
	input wire logic                        box_ready,
	input wire logic [fbcp_pkg::BYTE_W-1:0] box_x,
	input wire logic [fbcp_pkg::BYTE_W-1:0] box_height
);
	import fbcp_pkg::*;

	// A box beat can only start right after a byte was taken.
	a_box_needs_byte: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(box_valid) |-> $past(rx_valid && rx_ready))
		else $error("box beat appeared without an accepted byte");

	// With the output register empty, input is never held off.
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!box_valid |-> rx_ready)
		else $error("input stalled while output is empty");

	// A taken box beat is never followed by a new one without an accepted byte.
	a_no_spurious_box: assert property (@(posedge clk) disable iff (!arst_n)
		(box_valid && box_ready) |=> (!box_valid || $past(rx_valid && rx_ready)))
		else $error("second box beat without an accepted byte");

	a_box_held: assert property (@(posedge clk) disable iff (!arst_n)
		(box_valid && !box_ready) |=> (box_valid && $stable(box_x) && $stable(box_height)))
		else $error("stalled box beat changed");

endmodule

bind framed_box_coordinate_parser_core fbcp_checker u_fbcp_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.rx_valid   (rx.valid),
	.rx_ready   (rx.ready),
	.box_valid  (box.valid),
	.box_ready  (box.ready),
	.box_x      (box.box_x),
	.box_height (box.box_height)
);

`default_nettype wire
